FILE: sv/plte_pkg.sv
// Shared types, constants and the microcode table of the pc/line table encoder.
package plte_pkg;

	localparam int MAX_GAP_BYTES_DEF = 59;
	localparam int PC_QUANTUM = 4;
	localparam int GAP_STEP = 127;
	localparam int GAP_BASE = 128;
	localparam int LINE_SHORT = 64;
	localparam logic [7:0] LONG_MARK = 8'd0;
	localparam logic [7:0] PAD_BYTE = 8'd129;

	localparam int STEP_W = 4;

	// program steps
	localparam logic [STEP_W-1:0] S_FETCH  = 4'd0;
	localparam logic [STEP_W-1:0] S_DECODE = 4'd1;
	localparam logic [STEP_W-1:0] S_CHECK  = 4'd2;
	localparam logic [STEP_W-1:0] S_UPDATE = 4'd3;
	localparam logic [STEP_W-1:0] S_GAP    = 4'd4;
	localparam logic [STEP_W-1:0] S_LINE   = 4'd5;
	localparam logic [STEP_W-1:0] S_LONG   = 4'd6;
	localparam logic [STEP_W-1:0] S_RET    = 4'd7;
	localparam logic [STEP_W-1:0] S_PADCHK = 4'd8;
	localparam logic [STEP_W-1:0] S_PAD    = 4'd9;

	// byte sources
	localparam logic [1:0] B_GAP  = 2'd0;
	localparam logic [1:0] B_LINE = 2'd1;
	localparam logic [1:0] B_LONG = 2'd2;
	localparam logic [1:0] B_PAD  = 2'd3;

	// jump conditions
	localparam logic [3:0] C_ALWAYS    = 4'd0;
	localparam logic [3:0] C_NO_ACCEPT = 4'd1;
	localparam logic [3:0] C_FINISH    = 4'd2;
	localparam logic [3:0] C_SKIP      = 4'd3;
	localparam logic [3:0] C_GAP_ZERO  = 4'd4;
	localparam logic [3:0] C_GAP_MORE  = 4'd5;
	localparam logic [3:0] C_SHORT     = 4'd6;
	localparam logic [3:0] C_LONG_MORE = 4'd7;
	localparam logic [3:0] C_EVEN      = 4'd8;

	typedef struct packed {
		logic              op;
		logic [31:0]       pc;
		logic [30:0]       line;
		logic              pseudo;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last;
		logic       gap_error;
	} out_item_t;

	typedef struct packed {
		logic              fetch;
		logic              dec;
		logic              upd;
		logic              emit;
		logic [1:0]        bsel;
		logic [3:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctl;
		logic  fire;
	} seq_t;

	typedef struct packed {
		logic accept;
		logic finish;
		logic skip;
		logic gap_zero;
		logic gap_more;
		logic short_delta;
		logic long_more;
		logic even;
		logic emit_ok;
	} stat_t;

	function automatic ctrl_t cw(input logic fetch, input logic dec, input logic upd,
			input logic emit, input logic [1:0] bsel, input logic [3:0] cond,
			input logic [STEP_W-1:0] target);
		ctrl_t c;
		c.fetch  = fetch;
		c.dec    = dec;
		c.upd    = upd;
		c.emit   = emit;
		c.bsel   = bsel;
		c.cond   = cond;
		c.target = target;
		return c;
	endfunction

	// microcode: a taken condition jumps to target, otherwise the next step
	function automatic ctrl_t useq_rom(input logic [STEP_W-1:0] step);
		ctrl_t c;
		case (step)
			S_FETCH:  c = cw(1'b1, 1'b0, 1'b0, 1'b0, B_GAP,  C_NO_ACCEPT, S_FETCH);
			S_DECODE: c = cw(1'b0, 1'b1, 1'b0, 1'b0, B_GAP,  C_FINISH,    S_PADCHK);
			S_CHECK:  c = cw(1'b0, 1'b0, 1'b0, 1'b0, B_GAP,  C_SKIP,      S_FETCH);
			S_UPDATE: c = cw(1'b0, 1'b0, 1'b1, 1'b0, B_GAP,  C_GAP_ZERO,  S_LINE);
			S_GAP:    c = cw(1'b0, 1'b0, 1'b0, 1'b1, B_GAP,  C_GAP_MORE,  S_GAP);
			S_LINE:   c = cw(1'b0, 1'b0, 1'b0, 1'b1, B_LINE, C_SHORT,     S_FETCH);
			S_LONG:   c = cw(1'b0, 1'b0, 1'b0, 1'b1, B_LONG, C_LONG_MORE, S_LONG);
			S_RET:    c = cw(1'b0, 1'b0, 1'b0, 1'b0, B_GAP,  C_ALWAYS,    S_FETCH);
			S_PADCHK: c = cw(1'b0, 1'b0, 1'b0, 1'b0, B_GAP,  C_EVEN,      S_FETCH);
			S_PAD:    c = cw(1'b0, 1'b0, 1'b0, 1'b1, B_PAD,  C_ALWAYS,    S_FETCH);
			default:  c = cw(1'b0, 1'b0, 1'b0, 1'b0, B_GAP,  C_ALWAYS,    S_FETCH);
		endcase
		return c;
	endfunction

endpackage

FILE: sv/plte_chan_if.sv
// Valid/ready channel interface carrying one payload item.
interface plte_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/pc_line_table_encoder.sv
// Top level of the pc/line table encoder: sequencer plus datapath.
// Takes one item at a time and emits one table byte per cycle at most. A record costs
// four control steps (fetch, decode, skip check, state update), plus an emitting step for
// each pc gap byte and each line byte: a long line delta adds four delta bytes and a return
// step, a skipped record ends after the skip check, and a finish item is fetched, decoded
// and gets a pad step only on odd length. A stalled output holds the current step. Writes to
// text_base load the previous pc at once and are taken in any cycle.
module pc_line_table_encoder import plte_pkg::*; #(
	parameter int MAX_GAP_BYTES = MAX_GAP_BYTES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	plte_chan_if.sink     in_ch,
	plte_chan_if.source   out_ch,
	plte_chan_if.sink     cfg_ch
);

	seq_t  seq;
	stat_t stat;

	plte_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.seq    (seq)
	);

	plte_datapath #(
		.MAX_GAP_BYTES (MAX_GAP_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.seq       (seq),
		.stat      (stat),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_data   (in_ch.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data),
		.cfg_valid (cfg_ch.valid),
		.cfg_ready (cfg_ch.ready),
		.cfg_data  (cfg_ch.data)
	);

endmodule

FILE: sv/plte_useq.sv
// Microcode sequencer: step counter, control table and jump condition select.
module plte_useq import plte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output seq_t  seq
);

	logic [STEP_W-1:0] step_q;
	ctrl_t             ctl;
	logic              take;
	logic              fire;

	assign ctl = useq_rom(step_q);
	// an emitting step waits for room in the output register
	assign fire = !ctl.emit || stat.emit_ok;

	always_comb begin
		case (ctl.cond)
			C_ALWAYS:    take = 1'b1;
			C_NO_ACCEPT: take = !stat.accept;
			C_FINISH:    take = stat.finish;
			C_SKIP:      take = stat.skip;
			C_GAP_ZERO:  take = stat.gap_zero;
			C_GAP_MORE:  take = stat.gap_more;
			C_SHORT:     take = stat.short_delta;
			C_LONG_MORE: take = stat.long_more;
			C_EVEN:      take = stat.even;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_FETCH;
		end else if (fire) begin
			step_q <= take ? ctl.target : step_q + STEP_W'(1);
		end
	end

	assign seq.ctl  = ctl;
	assign seq.fire = fire;

endmodule

FILE: sv/plte_datapath.sv
// Datapath: input latch, gap and line delta decode, byte source mux, output register.
module plte_datapath import plte_pkg::*; #(
	parameter int MAX_GAP_BYTES = MAX_GAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_t        seq,
	output stat_t       stat,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int GAP_LIMIT = MAX_GAP_BYTES * GAP_STEP;
	localparam int UW = $clog2(GAP_LIMIT + 1);

	ctrl_t ctl;
	assign ctl = seq.ctl;

	// latched input item
	logic        op_q;
	logic [31:0] pc_q;
	logic [30:0] line_q;
	logic        pseudo_q;

	// table state
	logic [31:0] prev_pc_q;
	logic [31:0] prev_line_q;
	logic        odd_q;

	// per-record work registers
	logic [UW-1:0] units_q;
	logic          err_q;
	logic          skip_q;
	logic          short_q;
	logic [7:0]    sbyte_q;
	logic [31:0]   delta_q;
	logic [1:0]    cnt_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic        accept;
	logic [32:0] diff;
	logic [29:0] units_w;
	logic        dec_err;
	logic [31:0] delta_w;
	logic        pos_w;
	logic        neg_w;
	logic [7:0]  sbyte_w;
	logic        skip_w;
	logic        emit_ok;
	logic        emit_fire;
	out_item_t   byte_w;
	logic        gap_big;

	assign in_ready  = ctl.fetch;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_data.op;
			pc_q     <= in_data.pc;
			line_q   <= in_data.line;
			pseudo_q <= in_data.pseudo;
		end
	end

	// gap is taken unwrapped: bit 32 marks a negative gap
	assign diff    = {1'b0, pc_q} - {1'b0, prev_pc_q};
	assign units_w = diff[31:2];
	assign dec_err = diff[32] || (units_w > 30'(GAP_LIMIT));

	assign delta_w = {1'b0, line_q} - prev_line_q;
	assign pos_w   = (delta_w[31:7] == 25'd0) && (delta_w[6:0] != 7'd0)
		&& (delta_w[6:0] <= 7'(LINE_SHORT));
	assign neg_w   = &delta_w[31:6];
	assign sbyte_w = pos_w ? delta_w[7:0] : 8'(LINE_SHORT) - delta_w[7:0];
	assign skip_w  = pseudo_q || ({1'b0, line_q} == prev_line_q);

	assign gap_big   = units_q > UW'(GAP_STEP);
	assign emit_ok   = !out_valid_q || out_ready;
	assign emit_fire = seq.fire && ctl.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= '0;
			cnt_q   <= 2'd0;
		end else if (seq.fire && ctl.dec) begin
			units_q <= dec_err ? '0 : units_w[UW-1:0];
			cnt_q   <= 2'd0;
		end else if (emit_fire && ctl.bsel == B_GAP) begin
			units_q <= gap_big ? units_q - UW'(GAP_STEP) : '0;
		end else if (emit_fire && ctl.bsel == B_LONG) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.fire && ctl.dec) begin
			err_q   <= dec_err;
			skip_q  <= skip_w;
			short_q <= pos_w || neg_w;
			sbyte_q <= sbyte_w;
			delta_q <= delta_w;
		end else if (emit_fire && ctl.bsel == B_LONG) begin
			delta_q <= {delta_q[23:0], 8'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pc_q   <= 32'd0;
			prev_line_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			prev_pc_q <= cfg_data;
		end else if (seq.fire && ctl.upd) begin
			prev_pc_q   <= pc_q + 32'(PC_QUANTUM);
			prev_line_q <= {1'b0, line_q};
		end
	end

	always_comb begin
		byte_w.gap_error = err_q;
		case (ctl.bsel)
			B_GAP: begin
				byte_w.code_byte = gap_big ? 8'd255 : {1'b1, units_q[6:0]};
				byte_w.last      = 1'b0;
			end
			B_LINE: begin
				byte_w.code_byte = short_q ? sbyte_q : LONG_MARK;
				byte_w.last      = short_q;
			end
			B_LONG: begin
				byte_w.code_byte = delta_q[31:24];
				byte_w.last      = (cnt_q == 2'd3);
			end
			B_PAD: begin
				byte_w.code_byte = PAD_BYTE;
				byte_w.last      = 1'b1;
				byte_w.gap_error = 1'b0;
			end
			default: begin
				byte_w.code_byte = PAD_BYTE;
				byte_w.last      = 1'b1;
				byte_w.gap_error = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			odd_q       <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
			odd_q       <= !odd_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q <= byte_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.accept      = accept;
	assign stat.finish      = op_q;
	assign stat.skip        = skip_q;
	assign stat.gap_zero    = (units_q == '0);
	assign stat.gap_more    = gap_big;
	assign stat.short_delta = short_q;
	assign stat.long_more   = (cnt_q != 2'd3);
	assign stat.even        = !odd_q;
	assign stat.emit_ok     = emit_ok;

	a_err_no_units: assert property (@(posedge clk) disable iff (!arst_n)
		seq.fire && ctl.dec && dec_err |=> units_q == '0)
		else $error("gap error left pc units pending");

	a_units_range: assert property (@(posedge clk) disable iff (!arst_n)
		units_q <= UW'(GAP_LIMIT))
		else $error("pc units above encodable limit");

	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && ctl.bsel == B_GAP |-> units_q != '0)
		else $error("gap byte emitted with no units left");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> odd_q != $past(odd_q))
		else $error("length parity missed an emitted byte");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> emit_ok)
		else $error("byte loaded over an untaken result");

endmodule

FILE: dv/pc_line_table_encoder_tb.sv
// Testbench for pc_line_table_encoder: directed and random records checked byte by byte.
module pc_line_table_encoder_tb import plte_pkg::*;;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam int   SETTLE_CYCLES = 16;
	localparam int   HOLD_CYCLES = 300;
	localparam int   ITEMS_PER_PHASE = 70;
	localparam int   NUM_PHASES = 5;
	localparam int   CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;

	plte_chan_if #(.T(in_item_t))    in_ch ();
	plte_chan_if #(.T(out_item_t))   out_ch ();
	plte_chan_if #(.T(logic [31:0])) cfg_ch ();

	pc_line_table_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	in_item_t    record_queue[$];
	out_item_t   expected_bytes[$];

	// encoder state as predicted
	logic [31:0] enc_prev_pc;
	logic [31:0] enc_prev_line;
	logic        enc_odd;

	// rough copy of the table position, used only to shape stimulus
	logic [31:0] gen_pc;
	logic [30:0] gen_line;

	int          send_idle_pct;
	int          stall_pct;
	logic        hold_on;
	event        hold_go;
	int          mismatches;
	int          cycle_count;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		hold_on = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void add_byte(input logic [7:0] code, input logic err);
		out_item_t b;
		b.code_byte = code;
		b.last = 1'b0;
		b.gap_error = err;
		expected_bytes.push_back(b);
		enc_odd = ~enc_odd;
	endfunction

	function automatic void encode_record(input in_item_t it);
		logic signed [33:0] diff;
		logic [31:0]        delta;
		logic signed [31:0] sd;
		logic               err;
		int                 units;
		int                 chunk;
		int                 first;
		out_item_t          tail;
		first = expected_bytes.size();
		if (it.op == OP_FINISH) begin
			if (enc_odd)
				add_byte(PAD_BYTE, 1'b0);
		end else if (!it.pseudo && {1'b0, it.line} != enc_prev_line) begin
			// gap is exact, not wrapped
			diff = $signed({2'b00, it.pc}) - $signed({2'b00, enc_prev_pc});
			err = 1'b0;
			units = 0;
			if (diff < 0) begin
				err = 1'b1;
			end else begin
				units = int'(diff / PC_QUANTUM);
				if (units > MAX_GAP_BYTES_DEF * GAP_STEP) begin
					err = 1'b1;
					units = 0;
				end
			end
			while (units > 0) begin
				chunk = (units < GAP_STEP) ? units : GAP_STEP;
				add_byte(8'(GAP_BASE + chunk), err);
				units -= chunk;
			end
			delta = {1'b0, it.line} - enc_prev_line;
			sd = $signed(delta);
			if (sd >= 1 && sd <= LINE_SHORT) begin
				add_byte(delta[7:0], err);
			end else if (sd <= -1 && sd >= -LINE_SHORT) begin
				add_byte(8'(LINE_SHORT - sd), err);
			end else begin
				add_byte(LONG_MARK, err);
				add_byte(delta[31:24], err);
				add_byte(delta[23:16], err);
				add_byte(delta[15:8], err);
				add_byte(delta[7:0], err);
			end
			enc_prev_line = {1'b0, it.line};
			enc_prev_pc = it.pc + PC_QUANTUM;
		end
		if (expected_bytes.size() > first) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
	endfunction

	function automatic void queue_item(input in_item_t it);
		record_queue.push_back(it);
		if (it.op == OP_RECORD && !it.pseudo && it.line != gen_line) begin
			gen_pc = it.pc + PC_QUANTUM;
			gen_line = it.line;
		end
	endfunction

	function automatic void queue_record(input logic [31:0] pc, input logic [30:0] line,
			input logic pseudo);
		in_item_t it;
		it.op = OP_RECORD;
		it.pc = pc;
		it.line = line;
		it.pseudo = pseudo;
		queue_item(it);
	endfunction

	function automatic void queue_finish();
		in_item_t it;
		it.op = OP_FINISH;
		it.pc = $urandom;
		it.line = 31'($urandom);
		it.pseudo = 1'($urandom_range(1));
		queue_item(it);
	endfunction

	function automatic void queue_random_item();
		int          kind;
		int          sel;
		int          dl;
		int unsigned units;
		logic [31:0] pc;
		in_item_t    it;
		kind = $urandom_range(99);
		if (kind < 62) begin
			// record with a forward gap, rarely past the gap limit, mostly short line step
			sel = $urandom_range(19);
			if (sel < 2)
				units = 0;
			else if (sel < 4)
				units = $urandom_range(254, 126);
			else if (sel < 6)
				units = $urandom_range(900, 255);
			else if (sel == 6)
				units = $urandom_range(7494, 7380);
			else
				units = $urandom_range(12, 1);
			pc = gen_pc + 4 * units;
			if ($urandom_range(7) == 0)
				pc = pc + $urandom_range(3);
			sel = $urandom_range(9);
			if (sel < 7) begin
				dl = int'($urandom_range(66, 1));
				if ($urandom_range(1) == 1)
					dl = -dl;
			end else if (sel == 7) begin
				dl = 0;
			end else begin
				dl = $urandom;
			end
			queue_record(pc, gen_line + 31'(dl), 1'b0);
		end else if (kind < 70) begin
			queue_record(gen_pc + 4 * $urandom_range(5), 31'($urandom), 1'b1);
		end else if (kind < 80) begin
			queue_finish();
		end else if (kind < 88) begin
			queue_record(gen_pc - 4 * $urandom_range(100, 1),
				gen_line + 31'($urandom_range(3, 1)), 1'b0);
		end else begin
			it.op = 1'($urandom_range(1));
			it.pc = $urandom;
			it.line = 31'($urandom);
			it.pseudo = 1'($urandom_range(1));
			queue_item(it);
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				encode_record(in_ch.data);
			if (!in_ch.valid || in_ch.ready) begin
				if (record_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= record_queue.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		out_item_t got;
		out_item_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_bytes.size() == 0) begin
					$error("unexpected table byte: code_byte %0d last %0d gap_error %0d",
						got.code_byte, got.last, got.gap_error);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (got.code_byte !== want.code_byte) begin
						$error("code_byte: expected %0d, got %0d", want.code_byte, got.code_byte);
						mismatches++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						mismatches++;
					end
					if (got.gap_error !== want.gap_error) begin
						$error("gap_error: expected %0d, got %0d", want.gap_error, got.gap_error);
						mismatches++;
					end
				end
			end
			out_ch.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off so the block backs up into its input
	always begin
		@(hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_text_base(input logic [31:0] base);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= base;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		enc_prev_pc = base;
		gen_pc = base;
	endtask

	// skipped records and empty finishes leave the block busy with no byte to show for it
	task automatic drain();
		while (record_queue.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          p;
		int          n;
		logic [31:0] base;
		cycle_count = 0;
		mismatches = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		enc_prev_pc = '0;
		enc_prev_line = '0;
		enc_odd = 1'b0;
		gen_pc = '0;
		gen_line = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, text base at its reset value
		queue_record(32'h0, 31'd0, 1'b0);                  // first line 0 is skipped
		queue_finish();                                    // even length: no pad
		queue_record(gen_pc, 31'd1, 1'b0);
		queue_finish();                                    // pad byte
		queue_record(gen_pc + 4 * 127, 31'd65, 1'b0);      // one full gap byte, delta +64
		queue_record(gen_pc + 4 * 128, 31'd1, 1'b0);       // two gap bytes, delta -64
		queue_record(gen_pc + 8, 31'd2, 1'b1);             // pseudo
		queue_record(gen_pc + 4 * MAX_GAP_BYTES_DEF * GAP_STEP, 31'd66, 1'b0);
		queue_record(gen_pc + 4 * (MAX_GAP_BYTES_DEF * GAP_STEP + 1), 31'd1, 1'b0);
		queue_record(gen_pc - 4, 31'd0, 1'b0);             // negative gap
		queue_record(gen_pc + 3, 31'd1, 1'b0);             // unaligned, zero units
		queue_record(gen_pc + 7, 31'd2, 1'b0);
		queue_record(gen_pc + 4, 31'h7FFF_FFFF, 1'b0);
		queue_record(gen_pc, 31'd0, 1'b0);
		queue_record(32'hFFFF_FFFC, 31'd5, 1'b0);
		queue_record(32'h0, 31'd6, 1'b0);                  // previous pc wrapped to zero
		queue_record(gen_pc, 31'd6, 1'b0);                 // same line
		queue_record(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
		queue_item('{op: OP_FINISH, pc: 32'hFFFF_FFFF, line: 31'h7FFF_FFFF, pseudo: 1'b1});
		queue_finish();
		queue_item('{op: OP_RECORD, pc: 32'hFFFF_FFFF, line: 31'h7FFF_FFFF, pseudo: 1'b1});
		drain();

		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					base = 32'hFFFF_FFFF;
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					base = 32'h0000_1000;
					send_idle_pct = 64;
					stall_pct = 0;
				end
				2: begin
					base = 32'h8000_0002;
					send_idle_pct = 0;
					stall_pct = 64;
				end
				3: begin
					base = 32'h0;
					send_idle_pct = 23;
					stall_pct = 23;
				end
				default: begin
					base = $urandom;
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			write_text_base(base);
			@(negedge clk);
			if (p == NUM_PHASES - 1)
				-> hold_go;
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				queue_random_item();
			drain();
		end

		if (expected_bytes.size() != 0) begin
			$error("%0d table bytes never arrived", expected_bytes.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: pc_line_table_encoder.f
sv/plte_pkg.sv
sv/plte_chan_if.sv
sv/plte_useq.sv
sv/plte_datapath.sv
sv/pc_line_table_encoder.sv
dv/pc_line_table_encoder_tb.sv
